// File: rtl/core/gmcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmcp_pkg
// shared constants and types of the grid minimum cost path block
// ----------------------------------------------------------------------------
package gmcp_pkg;

	localparam int MAX_ROWS   = 8;
	localparam int MAX_COLS   = 1024;
	localparam int ROW_W      = 3;
	localparam int COL_W      = 10;
	localparam int NR_W       = 4;
	localparam int NC_W       = 11;
	localparam int WEIGHT_W   = 8;
	localparam int COST_W     = 18;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'd1;

	// register reset values
	localparam logic [NR_W-1:0] NUM_ROWS_RST = 4'd5;
	localparam logic [NC_W-1:0] NUM_COLS_RST = 11'd6;

	typedef logic [COST_W-1:0] cost_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic is_top;   // cell of row 0: up neighbor comes from the wrap chain
		logic is_last;  // cell of the last row in use
		logic dn_wrap;  // down neighbor wraps to row 0
		logic sel;      // cell of the row being filled
		logic wr;       // weight beat accepted
		logic copy;     // column complete: move current costs to previous
	} cell_ctl_t;

	// one result beat
	typedef struct packed {
		cost_t             min_cost;
		logic [ROW_W-1:0]  end_row;
	} res_t;

endpackage
`default_nettype wire

// File: rtl/core/gmcp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmcp_if
// valid/ready channels for weight beats in and result beats out
// ----------------------------------------------------------------------------
interface gmcp_in_if;
	logic                         valid;
	logic                         ready;
	logic [gmcp_pkg::WEIGHT_W-1:0] cell_weight;

	modport source (output valid, output cell_weight, input ready);
	modport sink (input valid, input cell_weight, output ready);
endinterface

interface gmcp_out_if;
	logic                        valid;
	logic                        ready;
	logic [gmcp_pkg::COST_W-1:0] min_cost;
	logic [gmcp_pkg::ROW_W-1:0]  end_row;

	modport source (output valid, output min_cost, output end_row, input ready);
	modport sink (input valid, input min_cost, input end_row, output ready);
endinterface
`default_nettype wire

// File: rtl/core/grid_min_cost_path_wrap_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_min_cost_path_wrap_top
// minimum cost path over a weighted grid with wraparound rows
// ----------------------------------------------------------------------------
// throughput: one weight beat per cycle while ready is high; each beat is finished by
//   the row of cells in the cycle it is accepted
// the result beat of a grid is registered in the output buffer from its last weight beat
// ready drops only while two result beats are held (output plus skid)
// reset clears row/column counters, best tracking and output valids, and sets
//   num_rows to 5 and num_cols to 6; the cost cells have no reset
// ----------------------------------------------------------------------------
module grid_min_cost_path_wrap_top (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_wr_en,
	input  wire [gmcp_pkg::CFG_IDX_W-1:0]      cfg_wr_idx,
	input  wire [gmcp_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
	gmcp_in_if.sink                            in_ch,
	gmcp_out_if.source                         out_ch
);
	import gmcp_pkg::*;

	// configuration
	logic [NR_W-1:0]  nr_q;
	logic [NC_W-1:0]  nc_q;
	logic [NR_W-1:0]  nr_use;
	logic [NC_W-1:0]  nc_use;

	// sequencing
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic             acc;
	logic             last_row;
	logic             last_col;
	logic             room;

	// best of the last column
	cost_t            best_q;
	logic [ROW_W-1:0] brow_q;
	cost_t            best_nxt;
	logic [ROW_W-1:0] brow_nxt;

	// cell row
	cell_ctl_t        ctl     [MAX_ROWS];
	cost_t            prev_c  [MAX_ROWS];
	cost_t            tail_c  [MAX_ROWS];
	cost_t            cand_c  [MAX_ROWS];
	cost_t            cand_sel;
	cost_t            new_cost;
	res_t             res;

	// out-of-range counts clamp to the usable range
	assign nr_use = (nr_q == '0) ? NR_W'(1) :
	                (nr_q > NR_W'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : nr_q;
	assign nc_use = (nc_q == '0) ? NC_W'(1) :
	                (nc_q > NC_W'(MAX_COLS)) ? NC_W'(MAX_COLS) : nc_q;

	assign in_ch.ready = room;
	assign acc         = in_ch.valid && room;

	// a row past the last one in use counts as the last row
	assign last_row = ({1'b0, row_q} >= (nr_use - NR_W'(1)));
	assign last_col = ({1'b0, col_q} >= (nc_use - NC_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nr_q <= NUM_ROWS_RST;
			nc_q <= NUM_COLS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_wr_idx)
				REG_NUM_ROWS: nr_q <= cfg_wr_data[NR_W-1:0];
				REG_NUM_COLS: nc_q <= cfg_wr_data[NC_W-1:0];
				default: ;
			endcase
		end
	end

	// cell row: each cell sees its neighbors' previous costs, and row 0 gets
	// the last used row's cost over the wrap chain
	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		localparam int UP = (i + MAX_ROWS - 1) % MAX_ROWS;
		localparam int DN = (i + 1) % MAX_ROWS;

		assign ctl[i].is_top  = (i == 0);
		assign ctl[i].is_last = (nr_use == NR_W'(i + 1));
		assign ctl[i].dn_wrap = (NR_W'(i + 1) >= nr_use);
		assign ctl[i].sel     = (row_q == ROW_W'(i));
		assign ctl[i].wr      = acc;
		assign ctl[i].copy    = acc && last_row;

		gmcp_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[i]),
			.new_cost  (new_cost),
			.up_in     (prev_c[UP]),
			.dn_in     (prev_c[DN]),
			.head_in   (prev_c[0]),
			.tail_in   ((i == MAX_ROWS - 1) ? prev_c[i] : tail_c[DN]),
			.prev_cost (prev_c[i]),
			.tail_out  (tail_c[i]),
			.cand      (cand_c[i])
		);
	end

	// pick the candidate of the row being filled
	always_comb begin
		cand_sel = '0;
		for (int i = 0; i < MAX_ROWS; i++) begin
			if (ctl[i].sel) cand_sel = cand_sel | cand_c[i];
		end
	end

	// first column has no predecessor
	assign new_cost = (col_q == '0) ? COST_W'(in_ch.cell_weight)
	                                : COST_W'(in_ch.cell_weight) + cand_sel;

	// row 0 restarts the search, later rows replace only on a strict win
	always_comb begin
		best_nxt = best_q;
		brow_nxt = brow_q;
		if (last_col && ((row_q == '0) || (new_cost < best_q))) begin
			best_nxt = new_cost;
			brow_nxt = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			best_q <= '0;
			brow_q <= '0;
		end else if (acc) begin
			best_q <= best_nxt;
			brow_q <= brow_nxt;
			if (last_row) begin
				row_q <= '0;
				col_q <= last_col ? '0 : col_q + COL_W'(1);
			end else begin
				row_q <= row_q + ROW_W'(1);
			end
		end
	end

	// result beat on the last cell of the grid
	assign res.min_cost = best_nxt;
	assign res.end_row  = brow_nxt;

	gmcp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc && last_row && last_col),
		.push_data (res),
		.room      (room),
		.out_ch    (out_ch)
	);

`ifndef SYNTHESIS
	a_grid_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && last_row && last_col) |=> (row_q == '0) && (col_q == '0))
		else $error("counters not cleared after the last cell of the grid");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !last_row) |=> (row_q == $past(row_q) + ROW_W'(1)))
		else $error("row counter did not advance");
`endif

endmodule
`default_nettype wire

// File: rtl/core/gmcp_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmcp_cell
// one grid row: previous and current column cost, best predecessor
// ----------------------------------------------------------------------------
module gmcp_cell (
	input  wire                 clk,
	input  gmcp_pkg::cell_ctl_t ctl,
	input  gmcp_pkg::cost_t     new_cost,   // cost of the cell being filled
	input  gmcp_pkg::cost_t     up_in,      // previous cost of row above
	input  gmcp_pkg::cost_t     dn_in,      // previous cost of row below
	input  gmcp_pkg::cost_t     head_in,    // previous cost of row 0
	input  gmcp_pkg::cost_t     tail_in,    // wrap chain from the row below
	output gmcp_pkg::cost_t     prev_cost,
	output gmcp_pkg::cost_t     tail_out,
	output gmcp_pkg::cost_t     cand
);
	import gmcp_pkg::*;

	cost_t prev_q;
	cost_t cur_q;
	cost_t up_c;
	cost_t dn_c;
	cost_t m_c;

	// wrap chain carries the previous cost of the last row in use toward row 0
	assign tail_out  = ctl.is_last ? prev_q : tail_in;
	assign up_c      = ctl.is_top ? tail_out : up_in;
	assign dn_c      = ctl.dn_wrap ? head_in : dn_in;
	assign prev_cost = prev_q;

	always_comb begin
		m_c = up_c;
		if (prev_q < m_c) m_c = prev_q;
		if (dn_c < m_c) m_c = dn_c;
	end

	assign cand = m_c;

	always_ff @(posedge clk) begin
		if (ctl.wr && ctl.sel) begin
			cur_q <= new_cost;
		end
		if (ctl.copy) begin
			prev_q <= ctl.sel ? new_cost : cur_q;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/gmcp_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmcp_out_buf
// output register with skid stage for result beats
// ----------------------------------------------------------------------------
module gmcp_out_buf (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               push,
	input  gmcp_pkg::res_t    push_data,
	output logic              room,
	gmcp_out_if.source        out_ch
);
	import gmcp_pkg::*;

	logic out_v_q;
	logic skid_v_q;
	res_t out_q;
	res_t skid_q;
	logic pop;

	assign pop              = out_v_q && out_ch.ready;
	assign room             = !skid_v_q;
	assign out_ch.valid     = out_v_q;
	assign out_ch.min_cost  = out_q.min_cost;
	assign out_ch.end_row   = out_q.end_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q) begin
				out_v_q <= push;
			end else if (pop) begin
				if (skid_v_q) begin
					skid_v_q <= push;
				end else begin
					out_v_q <= push;
				end
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q) begin
			out_q <= push_data;
		end else if (pop) begin
			if (skid_v_q) begin
				out_q  <= skid_q;
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat while the output register is empty");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_v_q && !out_ch.ready) |=> skid_v_q)
		else $error("result beat lost during output stall");
`endif

endmodule
`default_nettype wire

// File: test/gmcp_path_board_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gmcp_path_board_pkg
// expected best-path results for the grid minimum cost path block: follows
// every accepted weight beat and holds the results still due
// ----------------------------------------------------------------------------
package gmcp_path_board_pkg;

	import gmcp_pkg::*;

	class path_board;
		logic [NR_W-1:0]   num_rows;
		logic [NC_W-1:0]   num_cols;
		cost_t             prev_cost [MAX_ROWS];
		cost_t             cur_cost [MAX_ROWS];
		bit [MAX_ROWS-1:0] prev_set;
		bit [MAX_ROWS-1:0] cur_set;
		int unsigned       row_pos;
		int unsigned       col_pos;
		cost_t             best_cost;
		int unsigned       best_row;
		res_t              paths_due [$];
		int unsigned       mismatches;

		function new();
			num_rows   = NUM_ROWS_RST;
			num_cols   = NUM_COLS_RST;
			prev_set   = '0;
			cur_set    = '0;
			row_pos    = 0;
			col_pos    = 0;
			best_cost  = '0;
			best_row   = 0;
			mismatches = 0;
			foreach (prev_cost[k]) begin
				prev_cost[k] = '0;
				cur_cost[k]  = '0;
			end
		endfunction

		function int unsigned rows_used(logic [NR_W-1:0] raw);
			if (raw == '0) return 1;
			if (raw > NR_W'(MAX_ROWS)) return MAX_ROWS;
			return 32'(raw);
		endfunction

		function int unsigned cols_used(logic [NC_W-1:0] raw);
			if (raw == '0) return 1;
			if (raw > NC_W'(MAX_COLS)) return MAX_COLS;
			return 32'(raw);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NUM_ROWS: num_rows = data[NR_W-1:0];
				REG_NUM_COLS: num_cols = data[NC_W-1:0];
				default: ;
			endcase
		endfunction

		// weight beats still needed before the current grid yields its result
		function int unsigned cells_to_finish();
			int unsigned nr, nc, rows_left, cols_after;
			nr = rows_used(num_rows);
			nc = cols_used(num_cols);
			rows_left  = (row_pos >= nr - 1) ? 1 : nr - row_pos;
			cols_after = (col_pos >= nc - 1) ? 0 : nc - 1 - col_pos;
			return rows_left + cols_after * nr;
		endfunction

		// a row count may change mid-grid only if every row it reaches has a known cost
		function bit rows_safe(logic [NR_W-1:0] raw);
			int unsigned nr;
			nr = rows_used(raw);
			if (col_pos == 0) return 1'b1;
			for (int k = 0; k < nr; k++)
				if (!prev_set[k]) return 1'b0;
			return 1'b1;
		endfunction

		function int unsigned pending();
			return paths_due.size();
		endfunction

		function void note_weight(logic [WEIGHT_W-1:0] w);
			int unsigned nr, nc, r, up, dn;
			cost_t       lo, c;
			bit          last_row, last_col;
			res_t        due;
			nr = rows_used(num_rows);
			nc = cols_used(num_cols);
			r  = (row_pos >= MAX_ROWS) ? MAX_ROWS - 1 : row_pos;
			last_row = (r >= nr - 1);
			last_col = (col_pos >= nc - 1);
			if (col_pos == 0) begin
				c = cost_t'(w);
			end else begin
				up = (r == 0) ? nr - 1 : r - 1;
				dn = (r + 1 >= nr) ? 0 : r + 1;
				lo = prev_cost[up];
				if (prev_cost[r] < lo) lo = prev_cost[r];
				if (prev_cost[dn] < lo) lo = prev_cost[dn];
				c = lo + cost_t'(w);
			end
			cur_cost[r] = c;
			cur_set[r]  = 1'b1;
			if (last_col && (r == 0 || c < best_cost)) begin
				best_cost = c;
				best_row  = r;
			end
			if (last_row) begin
				prev_cost = cur_cost;
				prev_set  = cur_set;
				row_pos   = 0;
				if (last_col) begin
					due.min_cost = best_cost;
					due.end_row  = ROW_W'(best_row);
					paths_due.push_back(due);
					col_pos = 0;
				end else begin
					col_pos++;
				end
			end else begin
				row_pos = r + 1;
			end
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) $display("mismatch: %s", what);
		endfunction

		function void check_result(cost_t cost, logic [ROW_W-1:0] row);
			res_t due;
			if (paths_due.size() == 0) begin
				flag($sformatf("result beat with none due: min_cost %0d end_row %0d", cost, row));
				return;
			end
			due = paths_due.pop_front();
			if (cost !== due.min_cost)
				flag($sformatf("min_cost expected %0d got %0d", due.min_cost, cost));
			if (row !== due.end_row)
				flag($sformatf("end_row expected %0d got %0d", due.end_row, row));
		endfunction
	endclass

endpackage

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives weight beats into grid_min_cost_path_wrap_top under changing grid
// sizes and idle patterns, and checks every result beat against a board
// that recomputes the best path cost and its end row
// ----------------------------------------------------------------------------
module testbench;

	import gmcp_pkg::*;
	import gmcp_path_board_pkg::*;

	localparam int RANDOM_ITEMS = 600;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_wr_idx;
	logic [CFG_DATA_W-1:0] cfg_wr_data;

	// idle odds in percent, per phase
	int unsigned src_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned random_sent = 0;

	path_board board = new();

	gmcp_in_if  in_ch ();
	gmcp_out_if out_ch ();

	grid_min_cost_path_wrap_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_idx  (cfg_wr_idx),
		.cfg_wr_data (cfg_wr_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a beat never comes
	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

	// result side: ready changes on the falling edge, beats are taken on the rising one
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready = ($urandom_range(0, 99) >= sink_stall_pct);
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				board.check_result(out_ch.min_cost, out_ch.end_row);
		end
	end

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		// extremes, then tiny weights that make ties likely, then anything
		if (roll < 10) return ($urandom_range(0, 1) != 0) ? '1 : '0;
		if (roll < 30) return WEIGHT_W'($urandom_range(0, 3));
		return WEIGHT_W'($urandom);
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en   = 1'b1;
		cfg_wr_idx  = idx;
		cfg_wr_data = data;
		@(posedge clk);
		board.set_reg(idx, data);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// one weight beat, with a random gap ahead of it; valid stays high on return
	task automatic send_weight(input logic [WEIGHT_W-1:0] w);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_ch.valid       = 1'b0;
			in_ch.cell_weight = WEIGHT_W'($urandom);
			@(negedge clk);
		end
		in_ch.valid       = 1'b1;
		in_ch.cell_weight = w;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		board.note_weight(w);
		@(negedge clk);
	endtask

	// directed beats packed first byte highest
	task automatic send_run(input logic [63:0] pack, input int unsigned n);
		for (int k = 0; k < n; k++)
			send_weight(pack[63 - 8 * k -: 8]);
	endtask

	task automatic send_cells(input int unsigned n);
		repeat (n) begin
			send_weight(pick_weight());
			random_sent++;
		end
	endtask

	// drain all due results, then give a beat that ends no grid time to land
	task automatic settle();
		in_ch.valid = 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input int unsigned mode);
		case (mode)
			0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
			2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
			default: begin src_idle_pct = 34; sink_stall_pct = 34; end
		endcase
	endtask

	initial begin
		int unsigned           phase;
		int unsigned           roll;
		int unsigned           cut;
		logic [CFG_DATA_W-1:0] rows_word;
		logic [CFG_DATA_W-1:0] cols_word;

		in_ch.valid       = 1'b0;
		in_ch.cell_weight = '0;
		cfg_wr_en         = 1'b0;
		cfg_wr_idx        = '0;
		cfg_wr_data       = '0;
		arst_n            = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// a full grid at the reset size, five rows by six columns
		send_cells(board.cells_to_finish());
		settle();

		// eight rows, one column: weight extremes and a three-way tie on the minimum,
		// data bits above the row field set on the write
		write_reg(REG_NUM_ROWS, 11'h7F8);
		write_reg(REG_NUM_COLS, 11'd1);
		send_run(64'hFF00_AA55_00FF_0100, 8);
		settle();

		// zero in both registers acts as a single cell
		write_reg(REG_NUM_ROWS, 11'h550);
		write_reg(REG_NUM_COLS, 11'd0);
		send_run(64'hC800_0000_0000_0000, 1);
		settle();

		// a single row wraps onto itself
		write_reg(REG_NUM_ROWS, 11'd1);
		write_reg(REG_NUM_COLS, 11'd3);
		send_run(64'hFFFF_FF00_0000_0000, 3);
		settle();

		// two rows: up and down neighbors are the same row, final costs tie
		write_reg(REG_NUM_ROWS, 11'd2);
		write_reg(REG_NUM_COLS, 11'd2);
		send_run(64'h0509_0303_0000_0000, 4);
		settle();

		// row count above the limit acts as eight rows
		write_reg(REG_NUM_ROWS, 11'd15);
		write_reg(REG_NUM_COLS, 11'd1);
		send_run(64'h0706_0504_0302_0101, 8);
		settle();

		// random phases: mostly whole grids, some cut short so that the next
		// register writes land mid-grid
		random_sent = 0;
		phase = 0;
		while (random_sent < RANDOM_ITEMS) begin
			set_mode(phase % 4);
			if ($urandom_range(0, 99) < 70) begin
				rows_word = CFG_DATA_W'($urandom);
				roll = $urandom_range(0, 99);
				if (roll < 5)       rows_word[NR_W-1:0] = '0;
				else if (roll < 15) rows_word[NR_W-1:0] = NR_W'($urandom_range(9, 15));
				else                rows_word[NR_W-1:0] = NR_W'($urandom_range(1, MAX_ROWS));
				// growing rows mid-grid must not read costs never written
				if (board.rows_safe(rows_word[NR_W-1:0]))
					write_reg(REG_NUM_ROWS, rows_word);
				roll = $urandom_range(0, 99);
				if (roll < 8)       cols_word = '0;
				else if (roll < 16) cols_word = CFG_DATA_W'($urandom_range(7, 24));
				else                cols_word = CFG_DATA_W'($urandom_range(1, 6));
				write_reg(REG_NUM_COLS, cols_word);
			end
			if ($urandom_range(0, 99) < 20) begin
				cut = $urandom_range(1, board.cells_to_finish());
				send_cells(cut);
			end else begin
				repeat ($urandom_range(1, 3)) send_cells(board.cells_to_finish());
			end
			settle();
			phase++;
		end

		// let any stray result beat show up before the verdict
		repeat (20) @(negedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
